### src/icv_pkg.sv
// ----------------------------------------------------------------------------
// icv_pkg
// shared types, character codes and the weighted product table for the
// isbn check digit validator
// ----------------------------------------------------------------------------
package icv_pkg;

    // character codes
    localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_X_UP   = 8'h58;
    localparam logic [7:0] CHAR_X_LO   = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // kept character positions
    localparam logic [3:0] POS_TENTH   = 4'd9;
    localparam logic [3:0] POS_LEN10   = 4'd10;
    localparam logic [3:0] POS_LEN13   = 4'd13;
    localparam logic [3:0] KEPT_MAX    = 4'd14;

    // result format codes
    localparam logic [1:0] FMT_NONE    = 2'd0;
    localparam logic [1:0] FMT_ISBN10  = 2'd1;
    localparam logic [1:0] FMT_ISBN13  = 2'd2;

    // class of the tenth kept character
    localparam logic [1:0] TENTH_DIGIT = 2'd0;
    localparam logic [1:0] TENTH_X     = 2'd1;
    localparam logic [1:0] TENTH_OTHER = 2'd2;

    // default depth of the queue between front and back
    localparam int ICV_QUEUE_DEPTH = 4;

    // classified character as it travels through the queue
    typedef struct packed {
        logic       keep;   // not a hyphen or a space
        logic       digit;
        logic       is_x;
        logic [3:0] val;    // digit value, zero for a non-digit
        logic       last;
    } t_item;

    // ((pos + 1) * v) mod 11, indexed by {pos, v}
    typedef logic [3:0] t_mod11_tab [256];

    function automatic t_mod11_tab f_build_mod11_tab();
        t_mod11_tab tab;
        int         prod;
        for (int i = 0; i < 256; i++) begin
            prod = ((i >> 4) + 1) * (i & 15);
            for (int k = 0; k < 24; k++) begin
                if (prod >= 11) begin
                    prod = prod - 11;
                end
            end
            tab[i] = 4'(prod);
        end
        return tab;
    endfunction

    localparam t_mod11_tab MOD11_TAB = f_build_mod11_tab();

endpackage

### src/icv_front.sv
// ----------------------------------------------------------------------------
// icv_front
// accepts characters and classifies them into queue items
// ----------------------------------------------------------------------------
module icv_front
    import icv_pkg::*;
(
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_item      o_item
);

    logic w_digit;

    assign w_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);

    always_comb begin
        o_item.keep  = (i_char_code != CHAR_HYPHEN) && (i_char_code != CHAR_SPACE);
        o_item.digit = w_digit;
        o_item.is_x  = (i_char_code == CHAR_X_UP) || (i_char_code == CHAR_X_LO);
        // ascii digits carry their value in the low nibble
        o_item.val   = w_digit ? i_char_code[3:0] : 4'd0;
        o_item.last  = i_last_char;
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

### src/icv_queue.sv
// ----------------------------------------------------------------------------
// icv_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module icv_queue
    import icv_pkg::*;
#(
    parameter int DEPTH = ICV_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // occupancy never runs past the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    // pointers and count stay consistent
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty with unequal pointers");

endmodule

### src/icv_back.sv
// ----------------------------------------------------------------------------
// icv_back
// accumulates check sums and position flags, emits a verdict on the last item
// ----------------------------------------------------------------------------
module icv_back
    import icv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_valid,
    output logic [1:0] o_format_kind
);

    logic [3:0] r_kept_count, n_kept_count;
    logic [3:0] r_sum11, n_sum11;
    logic [3:0] r_sum10, n_sum10;
    logic       r_bad_prefix, n_bad_prefix;
    logic [1:0] r_tenth_class, n_tenth_class;
    logic       r_bad_tail, n_bad_tail;
    logic       r_out_valid;
    logic       r_out_is_valid;
    logic [1:0] r_out_kind;

    logic [3:0] w_v11;
    logic [3:0] w_term11;
    logic [4:0] w_add11;
    logic [4:0] w_term10;
    logic [5:0] w_add10;
    logic       w_res_valid;
    logic [1:0] w_res_kind;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = i_item_valid && (!i_item.last || w_out_free);

    always_comb begin
        // x counts as ten only at the tenth position
        w_v11    = (r_kept_count == POS_TENTH && i_item.is_x) ? 4'd10 : i_item.val;
        w_term11 = MOD11_TAB[{r_kept_count, w_v11}];
        w_add11  = {1'b0, r_sum11} + {1'b0, w_term11};
        // odd positions weigh three
        w_term10 = r_kept_count[0] ? ({1'b0, i_item.val} + {i_item.val, 1'b0})
                                   : {1'b0, i_item.val};
        w_add10  = {2'b00, r_sum10} + {1'b0, w_term10};

        n_kept_count  = r_kept_count;
        n_sum11       = r_sum11;
        n_sum10       = r_sum10;
        n_bad_prefix  = r_bad_prefix;
        n_tenth_class = r_tenth_class;
        n_bad_tail    = r_bad_tail;

        if (i_item.keep) begin
            if (r_kept_count < POS_LEN13) begin
                if (r_kept_count < POS_TENTH) begin
                    if (!i_item.digit) begin
                        n_bad_prefix = 1'b1;
                    end
                end else if (r_kept_count == POS_TENTH) begin
                    n_tenth_class = i_item.digit ? TENTH_DIGIT
                                  : (i_item.is_x ? TENTH_X : TENTH_OTHER);
                end else begin
                    if (!i_item.digit) begin
                        n_bad_tail = 1'b1;
                    end
                end
                if (r_kept_count <= POS_TENTH) begin
                    n_sum11 = (w_add11 >= 5'd11) ? 4'(w_add11 - 5'd11) : w_add11[3:0];
                end
                if (w_add10 >= 6'd30) begin
                    n_sum10 = 4'(w_add10 - 6'd30);
                end else if (w_add10 >= 6'd20) begin
                    n_sum10 = 4'(w_add10 - 6'd20);
                end else if (w_add10 >= 6'd10) begin
                    n_sum10 = 4'(w_add10 - 6'd10);
                end else begin
                    n_sum10 = w_add10[3:0];
                end
            end
            if (r_kept_count < KEPT_MAX) begin
                n_kept_count = r_kept_count + 4'd1;
            end
        end

        w_res_valid = 1'b0;
        w_res_kind  = FMT_NONE;
        if (n_kept_count == POS_LEN10) begin
            w_res_kind  = FMT_ISBN10;
            w_res_valid = !n_bad_prefix && (n_tenth_class != TENTH_OTHER)
                          && (n_sum11 == 4'd0);
        end else if (n_kept_count == POS_LEN13) begin
            w_res_kind  = FMT_ISBN13;
            w_res_valid = !n_bad_prefix && (n_tenth_class == TENTH_DIGIT)
                          && !n_bad_tail && (n_sum10 == 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_count  <= '0;
            r_sum11       <= '0;
            r_sum10       <= '0;
            r_bad_prefix  <= 1'b0;
            r_tenth_class <= TENTH_DIGIT;
            r_bad_tail    <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_kept_count  <= '0;
                r_sum11       <= '0;
                r_sum10       <= '0;
                r_bad_prefix  <= 1'b0;
                r_tenth_class <= TENTH_DIGIT;
                r_bad_tail    <= 1'b0;
            end else begin
                r_kept_count  <= n_kept_count;
                r_sum11       <= n_sum11;
                r_sum10       <= n_sum10;
                r_bad_prefix  <= n_bad_prefix;
                r_tenth_class <= n_tenth_class;
                r_bad_tail    <= n_bad_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_is_valid <= w_res_valid;
            r_out_kind     <= w_res_kind;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_valid    = r_out_is_valid;
    assign o_format_kind = r_out_kind;

    // a finished identifier always leaves a result and a cleared state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_out_valid && r_kept_count == '0
                                    && r_sum11 == '0 && r_sum10 == '0))
        else $error("last item did not produce result or clear state");

    // running sums stay reduced
    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum11 < 4'd11) && (r_sum10 < 4'd10) && (r_kept_count <= KEPT_MAX))
        else $error("sum or count out of range");

    // a pass verdict only comes with a recognized length
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_is_valid) |-> (r_out_kind == FMT_ISBN10
                                             || r_out_kind == FMT_ISBN13))
        else $error("pass reported without isbn length");

endmodule

### src/isbn_checksum_validator.sv
// ----------------------------------------------------------------------------
// isbn_checksum_validator
// streaming isbn-10 / isbn-13 check digit validator, one character per item
// ----------------------------------------------------------------------------
// Characters enter one per item with i_last_char marking the end of an
// identifier. Hyphens and spaces are skipped; each other character is kept
// and advances a saturating count (max 14), a weighted sum mod 11 for isbn-10
// (weight = position + 1) and a 1/3 alternating sum mod 10 for isbn-13. An x
// in either case counts as ten only at the tenth kept position. After the last
// character one result item gives o_format_kind (0 other length, 1 isbn-10,
// 2 isbn-13) and o_is_valid, and the running state is cleared for the next
// identifier. The front stage classifies each character and pushes it into a
// QUEUE_DEPTH entry queue; the back stage pops one item per cycle and updates
// the mod 11 sum with a constant product table plus one add and conditional
// subtract. Throughput is one character per clock while the queue is not
// full; a character is registered in the queue before the back stage sees
// it, and a result is registered when its last character is popped. Output
// stall only holds back last characters; others drain while a result waits.
// ----------------------------------------------------------------------------
module isbn_checksum_validator
    import icv_pkg::*;
#(
    parameter int QUEUE_DEPTH = ICV_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_valid,
    output logic [1:0] o_format_kind
);

    // front to queue
    logic  w_push;
    t_item w_push_item;
    logic  w_queue_full;

    // queue to back
    logic  w_pop;
    logic  w_head_valid;
    t_item w_head_item;

    // classify incoming characters
    icv_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    // decouples front acceptance from back stalls
    icv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head_item)
    );

    // sums, flags and the output register
    icv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_head_valid),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_is_valid    (o_is_valid),
        .o_format_kind (o_format_kind)
    );

endmodule
